// ===== hdl/ptc_pkg.sv =====
package ptc_pkg;

  localparam int unsigned AngleW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  localparam int unsigned InTdataW  = 72;
  localparam int unsigned OutTdataW = 104;

  typedef enum logic [CodeW-1:0] {
    CODE_GOOD    = 3'd0,
    CODE_SLOUCH  = 3'd1,
    CODE_FORWARD = 3'd2,
    CODE_LEFT    = 3'd3,
    CODE_RIGHT   = 3'd4,
    CODE_TENSION = 3'd5,
    CODE_UNKNOWN = 3'd6
  } code_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_FORWARD_LIMIT = 3'd0,
    REG_SLOUCH_LIMIT  = 3'd1,
    REG_LEFT_LIMIT    = 3'd2,
    REG_RIGHT_LIMIT   = 3'd3,
    REG_WINDOW        = 3'd4
  } reg_idx_t;

  localparam logic signed [AngleW-1:0] ForwardLimitReset = 16'sd2500;
  localparam logic signed [AngleW-1:0] SlouchLimitReset  = 16'sd1500;
  localparam logic signed [AngleW-1:0] LeftLimitReset    = -16'sd1500;
  localparam logic signed [AngleW-1:0] RightLimitReset   = 16'sd1500;
  localparam logic [TimeW-1:0]         WindowReset       = 32'd3000;

  // input beat fields
  typedef struct packed {
    logic [TimeW-1:0]         sample_time;
    logic signed [AngleW-1:0] roll_offset;
    logic signed [AngleW-1:0] pitch_offset;
    logic                     emg_tense;
    logic                     emg_ok;
    logic                     imu_ok;
  } in_beat_t;

  // output beat fields
  typedef struct packed {
    logic [TimeW-1:0] corrections_total;
    logic             correction_pulse;
    logic [TimeW-1:0] held_time;
    code_t            previous_code;
    code_t            posture_code;
    logic [TimeW-1:0] echo_time;
  } out_beat_t;

  function automatic logic is_bad(input code_t c);
    return (c != CODE_GOOD) && (c != CODE_UNKNOWN);
  endfunction

endpackage

// ===== hdl/posture_threshold_classifier.sv =====
// Channel  | Dir | Signals                       | Contents
// s_axis   | in  | s_tvalid s_tready s_tdata[72] | one feature sample per beat
// m_axis   | out | m_tvalid m_tready m_tdata[104]| one classification per beat
// apb      | in  | psel penable pwrite paddr ... | threshold and window registers
//
// One beat in per cycle, one beat out per cycle while m_axis is not stalled; a beat
// passes the input register, then the rule chain and window compare into the output register.
// State advances as a beat moves from the input register to the output register.
// rst (synchronous) clears the pipeline, the tracking state and the registers.
// A stalled m_axis holds the output register; s_tready then drops once the
// input register is also full.
module posture_threshold_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // imu_ok, emg_ok, emg_tense, pitch_offset[16], roll_offset[16], sample_time[32], 5'b0
  input  logic [ptc_pkg::InTdataW-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // echo_time[32], posture_code[3], previous_code[3], held_time[32],
  // correction_pulse, corrections_total[32], 1'b0
  output logic [ptc_pkg::OutTdataW-1:0]     m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptc_pkg::AddrW-1:0]         paddr,
  input  logic [ptc_pkg::DataW-1:0]         pwdata,
  output logic [ptc_pkg::DataW-1:0]         prdata,
  output logic                              pready
);

  localparam int unsigned InBeatW  = $bits(ptc_pkg::in_beat_t);
  localparam int unsigned OutBeatW = $bits(ptc_pkg::out_beat_t);

  // configuration
  logic signed [ptc_pkg::AngleW-1:0] forward_limit;
  logic signed [ptc_pkg::AngleW-1:0] slouch_limit;
  logic signed [ptc_pkg::AngleW-1:0] left_limit;
  logic signed [ptc_pkg::AngleW-1:0] right_limit;
  logic [ptc_pkg::TimeW-1:0]         window;

  logic                     cfg_wr;
  logic [ptc_pkg::RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ptc_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_limit <= ptc_pkg::ForwardLimitReset;
      slouch_limit  <= ptc_pkg::SlouchLimitReset;
      left_limit    <= ptc_pkg::LeftLimitReset;
      right_limit   <= ptc_pkg::RightLimitReset;
      window        <= ptc_pkg::WindowReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        ptc_pkg::REG_FORWARD_LIMIT: forward_limit <= pwdata[ptc_pkg::AngleW-1:0];
        ptc_pkg::REG_SLOUCH_LIMIT:  slouch_limit  <= pwdata[ptc_pkg::AngleW-1:0];
        ptc_pkg::REG_LEFT_LIMIT:    left_limit    <= pwdata[ptc_pkg::AngleW-1:0];
        ptc_pkg::REG_RIGHT_LIMIT:   right_limit   <= pwdata[ptc_pkg::AngleW-1:0];
        ptc_pkg::REG_WINDOW:        window        <= pwdata[ptc_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ptc_pkg::REG_FORWARD_LIMIT: prdata = {{(ptc_pkg::DataW-ptc_pkg::AngleW){1'b0}}, forward_limit};
      ptc_pkg::REG_SLOUCH_LIMIT:  prdata = {{(ptc_pkg::DataW-ptc_pkg::AngleW){1'b0}}, slouch_limit};
      ptc_pkg::REG_LEFT_LIMIT:    prdata = {{(ptc_pkg::DataW-ptc_pkg::AngleW){1'b0}}, left_limit};
      ptc_pkg::REG_RIGHT_LIMIT:   prdata = {{(ptc_pkg::DataW-ptc_pkg::AngleW){1'b0}}, right_limit};
      ptc_pkg::REG_WINDOW:        prdata = window;
      default:                    prdata = '0;
    endcase
  end

  // pipeline control
  logic in_valid;
  logic out_valid;
  logic out_free;
  logic advance;

  ptc_pkg::in_beat_t  in_beat;
  ptc_pkg::out_beat_t out_beat;
  ptc_pkg::out_beat_t out_beat_next;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_beat <= ptc_pkg::in_beat_t'(s_tdata[InBeatW-1:0]);
    end
    if (advance) begin
      out_beat <= out_beat_next;
    end
  end

  // tracking state
  ptc_pkg::code_t            cand_code, cand_code_next;
  logic [ptc_pkg::TimeW-1:0] cand_since, cand_since_next;
  ptc_pkg::code_t            held_code, held_code_next;
  logic [ptc_pkg::TimeW-1:0] held_since, held_since_next;
  logic                      alert_sent, alert_sent_next;
  ptc_pkg::code_t            shown_code;
  logic [ptc_pkg::TimeW-1:0] alert_total, alert_total_next;

  ptc_pkg::code_t raw;
  logic           confirmed;
  logic           pulse;
  logic [ptc_pkg::TimeW-1:0] now;

  assign now = in_beat.sample_time;

  always_comb begin
    if (!in_beat.imu_ok) begin
      raw = ptc_pkg::CODE_UNKNOWN;
    end else if (in_beat.emg_ok && in_beat.emg_tense) begin
      raw = ptc_pkg::CODE_TENSION;
    end else if (in_beat.pitch_offset >= forward_limit) begin
      raw = ptc_pkg::CODE_FORWARD;
    end else if (in_beat.pitch_offset >= slouch_limit) begin
      raw = ptc_pkg::CODE_SLOUCH;
    end else if (in_beat.roll_offset <= left_limit) begin
      raw = ptc_pkg::CODE_LEFT;
    end else if (in_beat.roll_offset >= right_limit) begin
      raw = ptc_pkg::CODE_RIGHT;
    end else begin
      raw = ptc_pkg::CODE_GOOD;
    end
  end

  always_comb begin
    cand_code_next  = raw;
    cand_since_next = (raw != cand_code) ? now : cand_since;
    alert_sent_next = (raw != cand_code) ? 1'b0 : alert_sent;
    confirmed       = (now - cand_since_next) >= window;
    held_code_next  = held_code;
    held_since_next = held_since;
    if (confirmed && (raw != held_code)) begin
      held_code_next  = raw;
      held_since_next = now;
    end
    pulse            = ptc_pkg::is_bad(held_code_next) && confirmed && !alert_sent_next;
    alert_total_next = alert_total + {{(ptc_pkg::TimeW-1){1'b0}}, pulse};
    if (pulse) begin
      alert_sent_next = 1'b1;
    end

    out_beat_next.echo_time         = now;
    out_beat_next.posture_code      = held_code_next;
    out_beat_next.previous_code     = shown_code;
    out_beat_next.held_time         = now - held_since_next;
    out_beat_next.correction_pulse  = pulse;
    out_beat_next.corrections_total = alert_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_code   <= ptc_pkg::CODE_GOOD;
      cand_since  <= '0;
      held_code   <= ptc_pkg::CODE_GOOD;
      held_since  <= '0;
      alert_sent  <= 1'b0;
      shown_code  <= ptc_pkg::CODE_GOOD;
      alert_total <= '0;
    end else if (advance) begin
      cand_code   <= cand_code_next;
      cand_since  <= cand_since_next;
      held_code   <= held_code_next;
      held_since  <= held_since_next;
      alert_sent  <= alert_sent_next;
      shown_code  <= held_code_next;
      alert_total <= alert_total_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(ptc_pkg::OutTdataW-OutBeatW){1'b0}}, out_beat};

endmodule

// ===== hdl/ptc_checker.sv =====
module ptc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ptc_pkg::OutTdataW-1:0] m_tdata
);

  ptc_pkg::out_beat_t beat;
  ptc_pkg::code_t     last_code;
  logic [ptc_pkg::TimeW-1:0] last_total;

  assign beat = ptc_pkg::out_beat_t'(m_tdata[$bits(ptc_pkg::out_beat_t)-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_code  <= ptc_pkg::CODE_GOOD;
      last_total <= '0;
    end else if (m_tvalid && m_tready) begin
      last_code  <= beat.posture_code;
      last_total <= beat.corrections_total;
    end
  end

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_prev: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> beat.previous_code == last_code)
    else $error("previous_code does not match last delivered code");

  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> beat.corrections_total ==
                 last_total + {{(ptc_pkg::TimeW-1){1'b0}}, beat.correction_pulse})
    else $error("corrections_total out of step with pulses");

  a_pulse_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && beat.correction_pulse |->
      beat.posture_code != ptc_pkg::CODE_GOOD && beat.posture_code != ptc_pkg::CODE_UNKNOWN)
    else $error("pulse on a good or unknown code");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

endmodule

bind posture_threshold_classifier ptc_checker u_ptc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
